[src/kplm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kplm_pkg
// Shared constants and types for the key prefix line merger.
// ----------------------------------------------------------------------------
package kplm_pkg;

   localparam int KEY_DEPTH = 32;
   localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int LEN_W     = $clog2(KEY_DEPTH + 1);
   localparam int POS_W     = 6;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [POS_W-1:0] POS_MAX      = 6'd63;
   localparam logic [LEN_W-1:0] KEY_DEPTH_LN = LEN_W'(KEY_DEPTH);
   localparam logic [POS_W-1:0] KEY_DEPTH_PS = POS_W'(KEY_DEPTH);

   localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd32;
   localparam logic [BYTE_W-1:0] TERM_RESET  = 8'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_DELIM = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM  = 1'd1;

   // one output beat handed from the sequencer to the output register
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              last;
   } beat_type;

endpackage

[src/kplm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kplm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kplm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/kplm_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kplm_out_reg
// Output register for the result channel; frees the sequencer from the sink.
// ----------------------------------------------------------------------------
module kplm_out_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  kplm_pkg::beat_type         beat_i,
   output logic                       slot_free,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [kplm_pkg::BYTE_W-1:0] rsp_tdata,  // [7:0] out_byte
   output logic                       rsp_tlast
);

   import kplm_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff;
   logic              last_ff;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      if (beat_i.valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (beat_i.valid) begin
         data_ff <= beat_i.data;
         last_ff <= beat_i.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

`ifndef SYNTHESIS
   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      beat_i.valid |-> slot_free)
      else $error("beat loaded while output slot is occupied");
`endif

endmodule

[src/kplm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kplm_ctrl
// Sequencer: decides each byte against the stored key, then walks the key
// store one entry at a time to emit the matched prefix.
// ----------------------------------------------------------------------------
module kplm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [kplm_pkg::BYTE_W-1:0]   req_tdata,
   input  logic                          req_tuser,
   input  logic                          csr_wr_en,
   input  logic [kplm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kplm_pkg::BYTE_W-1:0]   csr_wdata,
   output logic [kplm_pkg::KEY_AW-1:0]   ram_rd_addr,
   input  logic [kplm_pkg::BYTE_W-1:0]   ram_rd_data,
   output logic                          ram_wr_en,
   output logic [kplm_pkg::KEY_AW-1:0]   ram_wr_addr,
   output logic [kplm_pkg::BYTE_W-1:0]   ram_wr_data,
   input  logic                          slot_free,
   output kplm_pkg::beat_type            beat_o
);

   import kplm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECIDE, ST_TERM, ST_RD, ST_OUT, ST_ECHO
   } state_type;

   typedef enum logic [1:0] {
      MODE_FIRST = 2'd0, MODE_MATCH = 2'd1, MODE_BUILD = 2'd2, MODE_TAIL = 2'd3
   } mode_type;

   state_type         state_ff;
   mode_type          mode_ff, mode_in;
   logic [LEN_W-1:0]  key_len_ff, key_len_in;
   logic [POS_W-1:0]  line_pos_ff, line_pos_in;
   logic [BYTE_W-1:0] delim_ff, term_ff;
   logic              item_kind_ff;
   logic [BYTE_W-1:0] item_byte_ff;
   logic [LEN_W-1:0]  emit_len_ff, emit_len_in;
   logic              echo_ff, echo_in;
   logic              do_emit;
   logic [KEY_AW-1:0] idx_ff;

   logic              is_term, is_delim, lp_lt_kl, lp_ne_kl, hit, append;
   logic [LEN_W-1:0]  lp_clamp, kl_tmp;
   logic              idx_last;

   assign req_tready = (state_ff == ST_IDLE);

   // decision for the held byte; read data is key_store[line_pos]
   always_comb begin
      is_term  = (item_byte_ff == term_ff);
      is_delim = (item_byte_ff == delim_ff);
      lp_lt_kl = line_pos_ff < POS_W'(key_len_ff);
      lp_ne_kl = line_pos_ff != POS_W'(key_len_ff);
      lp_clamp = (line_pos_ff > KEY_DEPTH_PS) ? KEY_DEPTH_LN : LEN_W'(line_pos_ff);
      hit      = lp_lt_kl && (ram_rd_data == item_byte_ff);
      kl_tmp   = key_len_ff;
      mode_in  = mode_ff;
      do_emit  = 1'b0;
      echo_in  = 1'b0;
      append   = 1'b0;
      if (item_kind_ff) begin
         if ((mode_ff == MODE_MATCH) && lp_lt_kl) begin
            kl_tmp  = LEN_W'(line_pos_ff);
            do_emit = 1'b1;
         end
         mode_in = MODE_FIRST;
      end else if (is_term) begin
         if ((mode_ff == MODE_MATCH) && lp_ne_kl) begin
            kl_tmp  = lp_clamp;
            do_emit = 1'b1;
         end else if (mode_ff == MODE_BUILD) begin
            kl_tmp = lp_clamp;
         end
         mode_in = MODE_MATCH;
      end else if (is_delim) begin
         if ((mode_ff == MODE_MATCH) && lp_ne_kl) begin
            kl_tmp  = lp_clamp;
            do_emit = 1'b1;
         end
         mode_in = MODE_TAIL;
         echo_in = 1'b1;
      end else begin
         case (mode_ff)
            MODE_FIRST, MODE_BUILD: begin
               append  = 1'b1;
               echo_in = 1'b1;
            end
            MODE_MATCH: begin
               if (!hit) begin
                  kl_tmp  = lp_lt_kl ? LEN_W'(line_pos_ff) : key_len_ff;
                  do_emit = 1'b1;
                  mode_in = MODE_BUILD;
                  append  = 1'b1;
                  echo_in = 1'b1;
               end
            end
            default: begin
               echo_in = 1'b1;
            end
         endcase
      end

      emit_len_in = kl_tmp;
      ram_wr_en   = (state_ff == ST_DECIDE) && append && (kl_tmp < KEY_DEPTH_LN);
      ram_wr_addr = kl_tmp[KEY_AW-1:0];
      ram_wr_data = item_byte_ff;

      if (item_kind_ff) begin
         key_len_in = '0;
      end else if (append && (kl_tmp < KEY_DEPTH_LN)) begin
         key_len_in = kl_tmp + LEN_W'(1);
      end else begin
         key_len_in = kl_tmp;
      end

      if (item_kind_ff || is_term) begin
         line_pos_in = '0;
      end else if (line_pos_ff < POS_MAX) begin
         line_pos_in = line_pos_ff + POS_W'(1);
      end else begin
         line_pos_in = line_pos_ff;
      end
   end

   // read the compare entry at accept, the key entry being emitted otherwise
   always_comb begin
      if ((state_ff == ST_IDLE) && (line_pos_ff < KEY_DEPTH_PS)) begin
         ram_rd_addr = line_pos_ff[KEY_AW-1:0];
      end else if (state_ff == ST_IDLE) begin
         ram_rd_addr = '0;
      end else begin
         ram_rd_addr = idx_ff;
      end
   end

   assign idx_last = ((LEN_W'(idx_ff) + LEN_W'(1)) == emit_len_ff);

   always_comb begin
      beat_o.valid = 1'b0;
      beat_o.data  = item_byte_ff;
      beat_o.last  = 1'b1;
      unique case (state_ff)
         ST_TERM: begin
            beat_o.valid = slot_free;
            beat_o.data  = term_ff;
            beat_o.last  = (emit_len_ff == '0) && !echo_ff;
         end
         ST_OUT: begin
            beat_o.valid = slot_free;
            beat_o.data  = ram_rd_data;
            beat_o.last  = idx_last && !echo_ff;
         end
         ST_ECHO: begin
            beat_o.valid = slot_free;
         end
         default: begin
            beat_o.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mode_ff     <= MODE_FIRST;
         key_len_ff  <= '0;
         line_pos_ff <= '0;
         delim_ff    <= DELIM_RESET;
         term_ff     <= TERM_RESET;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_DELIM: delim_ff <= csr_wdata;
               CSR_TERM:  term_ff  <= csr_wdata;
               default:   ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  item_kind_ff <= req_tuser;
                  item_byte_ff <= req_tdata;
                  state_ff     <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               mode_ff     <= mode_in;
               key_len_ff  <= key_len_in;
               line_pos_ff <= line_pos_in;
               emit_len_ff <= emit_len_in;
               echo_ff     <= echo_in;
               if (do_emit) begin
                  state_ff <= ST_TERM;
               end else if (echo_in) begin
                  state_ff <= ST_ECHO;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_TERM: begin
               if (slot_free) begin
                  idx_ff <= '0;
                  if (emit_len_ff != '0) begin
                     state_ff <= ST_RD;
                  end else if (echo_ff) begin
                     state_ff <= ST_ECHO;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_RD: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (slot_free) begin
                  if (!idx_last) begin
                     idx_ff   <= idx_ff + KEY_AW'(1);
                     state_ff <= ST_RD;
                  end else if (echo_ff) begin
                     state_ff <= ST_ECHO;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_ECHO: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_key_len_bound: assert property (@(posedge clock) disable iff (reset)
      key_len_ff <= KEY_DEPTH_LN)
      else $error("key length beyond key store depth");

   a_first_line_len: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_FIRST) |->
         (POS_W'(key_len_ff) ==
          ((line_pos_ff > KEY_DEPTH_PS) ? KEY_DEPTH_PS : line_pos_ff)))
      else $error("first line key length out of step with line position");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (beat_o.valid && beat_o.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after last beat of an item");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (LEN_W'(idx_ff) < emit_len_ff))
      else $error("emit index past matched prefix");
`endif

endmodule

[src/key_prefix_line_merger_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_prefix_line_merger_unit
// Merges consecutive text lines sharing a key into one output line.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tdata[7:0] data_byte, tuser kind
//   rsp_     out  rsp_tvalid/rsp_tready  tdata[7:0] out_byte, tlast last_of_run
//   csr_     in   csr_wr_en              csr_index, csr_wdata[7:0]
//
// A byte that produces no beat passes ST_IDLE and ST_DECIDE, an echoed byte
// also ST_ECHO. Emitting a key sends the terminator from ST_TERM, then each key
// byte via ST_RD and ST_OUT, for the registered read of the key store walked.
// Reset is synchronous; the key store needs no clearing pass.
// Input is taken only while the sequencer idles; output stalls hold the
// sequencer, while a finished beat waits in the output register.
// ----------------------------------------------------------------------------
module key_prefix_line_merger_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [kplm_pkg::BYTE_W-1:0]    req_tdata,   // [7:0] data_byte
   input  logic                           req_tuser,   // [0] kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [kplm_pkg::BYTE_W-1:0]    rsp_tdata,   // [7:0] out_byte
   output logic                           rsp_tlast,
   input  logic                           csr_wr_en,
   input  logic [kplm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kplm_pkg::BYTE_W-1:0]    csr_wdata
);

   import kplm_pkg::*;

   logic [KEY_AW-1:0] ram_rd_addr, ram_wr_addr;
   logic [BYTE_W-1:0] ram_rd_data, ram_wr_data;
   logic              ram_wr_en;
   logic              slot_free;
   beat_type          beat;

   kplm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .slot_free   (slot_free),
      .beat_o      (beat)
   );

   kplm_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (KEY_DEPTH),
      .AW    (KEY_AW)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   kplm_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .beat_i     (beat),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[sim/key_prefix_line_merger_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_prefix_line_merger_unit_tb
// Self-checking bench for the key prefix line merger.
//
// Text lines are streamed into the block byte by byte. A behavioral model of
// the merge keeps its own copy of the stored key and line state and queues the
// bytes that each accepted beat should produce. Every output beat is checked
// against that queue. Both stream sides idle at random. The run starts with
// hand-picked lines and then checks key saturation with over-long keys. It
// ends with random lines from a small key pool under several separator
// settings.
// ----------------------------------------------------------------------------
module key_prefix_line_merger_unit_tb;
   import kplm_pkg::*;

   localparam int      SETTLE_CYCLES = 12;
   localparam longint  TIMEOUT_NS    = 10_000_000;
   localparam int      POOL_SLOTS    = 4;
   localparam int      POOL_BYTES    = 40;
   localparam int      LONG_KEY_LEN  = 34;

   typedef enum logic [1:0] {
      MODE_FIRST,
      MODE_MATCH,
      MODE_BUILD,
      MODE_TAIL
   } merge_mode_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } out_beat_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [BYTE_W-1:0]    rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   // model of the merge
   logic [BYTE_W-1:0] delim_byte;
   logic [BYTE_W-1:0] term_byte;
   merge_mode_type    mode;
   logic [BYTE_W-1:0] key_mem [KEY_DEPTH];
   int                key_len;
   int                line_pos;
   out_beat_type      pending_out [$];

   // line generator
   logic [BYTE_W-1:0] key_pool [POOL_SLOTS][POOL_BYTES];
   int                key_pool_len [POOL_SLOTS];

   int items_sent;
   int mismatch_count;
   bit req_quiet;
   bit rsp_quiet;

   key_prefix_line_merger_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic int clamp_key(input int v);
      return (v < KEY_DEPTH) ? v : KEY_DEPTH;
   endfunction

   function automatic void push_byte(input logic [BYTE_W-1:0] b);
      pending_out.push_back('{data: b, last: 1'b0});
   endfunction

   // terminator first, then the stored prefix
   function automatic void push_key();
      push_byte(term_byte);
      for (int i = 0; i < key_len; i++)
         push_byte(key_mem[i]);
   endfunction

   function automatic void append_key(input logic [BYTE_W-1:0] b);
      if (key_len < KEY_DEPTH) begin
         key_mem[key_len] = b;
         key_len++;
      end
   endfunction

   function automatic void predict_merge(input logic flush, input logic [BYTE_W-1:0] c);
      int first_new;
      first_new = pending_out.size();
      if (flush) begin
         if (mode == MODE_MATCH && line_pos < key_len) begin
            key_len = line_pos;
            push_key();
         end
         mode     = MODE_FIRST;
         key_len  = 0;
         line_pos = 0;
      end else if (c == term_byte) begin
         if (mode == MODE_MATCH && line_pos != key_len) begin
            key_len = clamp_key(line_pos);
            push_key();
         end else if (mode == MODE_BUILD) begin
            key_len = clamp_key(line_pos);
         end
         mode = MODE_MATCH;
      end else if (c == delim_byte) begin
         if (mode == MODE_MATCH && line_pos != key_len) begin
            key_len = clamp_key(line_pos);
            push_key();
         end
         mode = MODE_TAIL;
         push_byte(c);
      end else begin
         case (mode)
            MODE_FIRST, MODE_BUILD: begin
               append_key(c);
               push_byte(c);
            end
            MODE_MATCH: begin
               // swallow while the byte repeats the stored key
               if (!(line_pos < key_len && key_mem[line_pos] == c)) begin
                  key_len = clamp_key((line_pos < key_len) ? line_pos : key_len);
                  push_key();
                  mode = MODE_BUILD;
                  append_key(c);
                  push_byte(c);
               end
            end
            default: push_byte(c);
         endcase
      end

      if (!flush) begin
         if (c == term_byte)
            line_pos = 0;
         else if (line_pos < int'(POS_MAX))
            line_pos++;
      end

      if (pending_out.size() > first_new)
         pending_out[pending_out.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_item(input logic flush, input logic [BYTE_W-1:0] b);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= flush;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_merge(flush, b);
      items_sent++;
      @(negedge clock);
   endtask

   // drop valid, wait out every queued byte plus the block's own latency
   task automatic settle_outputs();
      req_tvalid <= 1'b0;
      while (pending_out.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_separators(input logic [BYTE_W-1:0] d, input logic [BYTE_W-1:0] t);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DELIM;
      csr_wdata <= d;
      @(negedge clock);
      csr_index <= CSR_TERM;
      csr_wdata <= t;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      delim_byte = d;
      term_byte  = t;
   endtask

   function automatic logic [BYTE_W-1:0] key_char();
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(0, 255));
      while (b == delim_byte || b == term_byte) b = BYTE_W'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] tail_char();
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(0, 255));
      while (b == term_byte) b = BYTE_W'($urandom_range(0, 255));
      return b;
   endfunction

   // slot 1 extends slot 0 so that prefix matches come up often
   function automatic void refill_key_pool();
      for (int s = 0; s < POOL_SLOTS; s++)
         for (int i = 0; i < POOL_BYTES; i++)
            key_pool[s][i] = key_char();
      key_pool_len[0] = $urandom_range(1, 6);
      key_pool_len[1] = key_pool_len[0] + $urandom_range(1, 3);
      key_pool_len[2] = $urandom_range(1, 4);
      key_pool_len[3] = $urandom_range(2, 8);
      for (int i = 0; i < key_pool_len[0]; i++)
         key_pool[1][i] = key_pool[0][i];
   endfunction

   task automatic send_key(input int slot, input int len);
      for (int i = 0; i < len; i++)
         send_item(1'b0, key_pool[slot][i]);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(1'b0, s[i]);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_merge();
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      send_text("ab x\n");
      send_text("ab y\n");          // same key: only the tail is echoed
      send_text("a\n");             // early terminator
      send_item(1'b0, 8'h00);       // mismatch at first byte, empty prefix
      send_item(1'b0, 8'hFF);
      send_text("\n");
      send_item(1'b0, 8'h00);       // partial match, then flush
      send_item(1'b1, 8'hA5);
      send_item(1'b1, 8'h00);       // flush with nothing pending
      send_text(" \n");             // delimiter opens the very first line
      send_text("z");               // empty stored key, mismatch at once
      send_item(1'b1, 8'hFF);
      send_text("k v\nk");          // match, then delimiter cut short below
      send_text("\n");
      settle_outputs();
   endtask

   // key longer than the store: length saturates at the store depth
   task automatic test_long_key_saturation();
      req_quiet = 1'b1;
      rsp_quiet = 1'b0;
      refill_key_pool();
      key_pool_len[0] = LONG_KEY_LEN;
      send_item(1'b1, 8'h00);
      send_key(0, LONG_KEY_LEN);
      send_item(1'b0, delim_byte);
      repeat (4) send_item(1'b0, tail_char());
      send_item(1'b0, term_byte);
      send_key(0, LONG_KEY_LEN);    // full stored key goes out in one burst
      send_item(1'b0, term_byte);
      settle_outputs();
   endtask

   task automatic test_random_lines(input logic [BYTE_W-1:0] d, input logic [BYTE_W-1:0] t,
                                    input int n, input bit quiet);
      int stop_at;
      int slot;
      int len;
      int roll;
      write_separators(d, t);
      req_quiet = quiet;
      rsp_quiet = quiet;
      refill_key_pool();
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         roll = $urandom_range(0, 9);
         if (roll == 0) begin
            // noise: any byte, separators and flushes included
            repeat ($urandom_range(1, 4))
               send_item($urandom_range(0, 7) == 0, BYTE_W'($urandom_range(0, 255)));
         end else begin
            slot = $urandom_range(0, POOL_SLOTS - 1);
            len  = key_pool_len[slot];
            if (roll == 1 && len > 1)
               len = $urandom_range(1, len - 1);
            if (roll == 2) begin
               send_key(slot, len - 1);
               send_item(1'b0, key_char());
            end else begin
               send_key(slot, len);
            end
            if (roll != 3) begin
               send_item(1'b0, d);
               repeat ($urandom_range(0, 5)) send_item(1'b0, tail_char());
            end
            if (roll == 4)
               send_item(1'b1, BYTE_W'($urandom_range(0, 255)));
            else
               send_item(1'b0, t);
         end
      end
      settle_outputs();
   endtask

   // ---------------------------------------------------------------- output side

   initial begin : rsp_stall_gen
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         stall = rsp_quiet ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (reset || !rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      out_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_out.size() == 0) begin
            $error("out_byte %02h arrived with no byte expected", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_out.pop_front();
            if (rsp_tdata !== want.data) begin
               $error("out_byte: expected %02h, actual %02h", want.data, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_run: expected %0b, actual %0b", want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_DELIM;
      csr_wdata      = '0;
      delim_byte     = DELIM_RESET;
      term_byte      = TERM_RESET;
      mode           = MODE_FIRST;
      key_len        = 0;
      line_pos       = 0;
      items_sent     = 0;
      mismatch_count = 0;
      req_quiet      = 1'b0;
      rsp_quiet      = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_merge();
      test_long_key_saturation();
      test_random_lines(DELIM_RESET, TERM_RESET, 5, 1'b0);
      test_random_lines(8'h00, 8'hFF, 5, 1'b0);
      test_random_lines(8'h41, 8'h41, 5, 1'b0);   // equal: terminator wins
      test_random_lines(8'hFF, 8'h00, 5, 1'b0);
      test_random_lines(BYTE_W'($urandom_range(0, 255)),
                        BYTE_W'($urandom_range(0, 255)), 5, 1'b1);

      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
